// ===== hw/rtl/object_file_section_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// object file section parser - assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef OBJECT_FILE_SECTION_PARSER_CORE_DEFINES_SVH
`define OBJECT_FILE_SECTION_PARSER_CORE_DEFINES_SVH

// checked only while out of reset
`define OFSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define OFSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ofsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ofsp_pkg
// types, codes and constants of the object file section parser
// ----------------------------------------------------------------------------
package ofsp_pkg;

  localparam logic [15:0] TAG_CODE   = 16'hCADE;
  localparam logic [15:0] TAG_DATA   = 16'hDADA;
  localparam logic [15:0] TAG_SYMBOL = 16'hC3B7;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CODE    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_LABEL   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_TAG_HI   = 3'd0,
    PH_TAG_LO   = 3'd1,
    PH_ADDR_HI  = 3'd2,
    PH_ADDR_LO  = 3'd3,
    PH_COUNT_HI = 3'd4,
    PH_COUNT_LO = 3'd5,
    PH_BODY     = 3'd6,
    PH_WORD_LO  = 3'd7
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] target_address;
    logic [15:0] value;
    logic        label_end;
  } result_t;

endpackage

// ===== hw/rtl/ofsp_front.sv =====
// ----------------------------------------------------------------------------
// ofsp_front
// byte parser: tracks the section header and body, builds result records
// ----------------------------------------------------------------------------
module ofsp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output logic             push,
  output ofsp_pkg::result_t result
);
  import ofsp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  hold, hold_next;
  logic [15:0] tag, tag_next;
  logic [15:0] addr, addr_next;
  logic [15:0] count, count_next;

  logic [15:0] word;
  logic        is_word;
  logic        last_one;

  assign word     = {hold, in_byte};
  assign is_word  = (tag == TAG_CODE) || (tag == TAG_DATA);
  assign last_one = (count == 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TAG_HI;
      hold  <= '0;
      tag   <= '0;
      addr  <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      hold  <= hold_next;
      tag   <= tag_next;
      addr  <= addr_next;
      count <= count_next;
    end
  end

  always_comb begin
    phase_next = phase;
    hold_next  = hold;
    tag_next   = tag;
    addr_next  = addr;
    count_next = count;
    push       = 1'b0;
    result     = '{kind: KIND_UNKNOWN, target_address: addr, value: tag, label_end: 1'b0};
    if (accept) begin
      unique case (phase)
        PH_TAG_HI, PH_ADDR_HI, PH_COUNT_HI: begin
          hold_next  = in_byte;
          phase_next = phase_t'(phase + 3'd1);
        end
        PH_TAG_LO: begin
          tag_next   = word;
          phase_next = PH_ADDR_HI;
        end
        PH_ADDR_LO: begin
          addr_next  = word;
          phase_next = PH_COUNT_HI;
        end
        PH_COUNT_LO: begin
          count_next = word;
          if (is_word || tag == TAG_SYMBOL) begin
            phase_next = (word == 16'd0) ? PH_TAG_HI : PH_BODY;
          end else begin
            // unknown tag: report it and start over on the next header
            phase_next = PH_TAG_HI;
            push       = 1'b1;
          end
        end
        PH_BODY: begin
          if (is_word) begin
            hold_next  = in_byte;
            phase_next = PH_WORD_LO;
          end else begin
            count_next = count - 16'd1;
            phase_next = last_one ? PH_TAG_HI : PH_BODY;
            push       = 1'b1;
            result     = '{kind: KIND_LABEL, target_address: addr,
                           value: {8'd0, in_byte}, label_end: last_one};
          end
        end
        PH_WORD_LO: begin
          addr_next  = addr + 16'd1;
          count_next = count - 16'd1;
          phase_next = last_one ? PH_TAG_HI : PH_BODY;
          push       = 1'b1;
          result     = '{kind: (tag == TAG_CODE) ? KIND_CODE : KIND_DATA,
                         target_address: addr, value: word, label_end: 1'b0};
        end
        default: phase_next = PH_TAG_HI;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ofsp_queue.sv =====
// ----------------------------------------------------------------------------
// ofsp_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module ofsp_queue #(
  parameter int DEPTH = ofsp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ofsp_pkg::result_t push_data,
  input  logic              pop,
  output ofsp_pkg::result_t head,
  output logic              empty,
  output logic              full
);
  import ofsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fill;

  logic do_push, do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ofsp_back.sv =====
// ----------------------------------------------------------------------------
// ofsp_back
// output register: takes records from the queue and drives the master side
// ----------------------------------------------------------------------------
module ofsp_back (
  input  logic              clk,
  input  logic              rst,
  input  ofsp_pkg::result_t head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);
  import ofsp_pkg::*;

  result_t held;

  // refill whenever the queue holds a record and the register is free or being emptied this cycle
  assign pop = !empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  assign m_tdata = {held.value, held.target_address};
  assign m_tuser = held.kind;
  assign m_tlast = held.label_end;

endmodule

// ===== hw/rtl/object_file_section_parser_core.sv =====
// ----------------------------------------------------------------------------
// object_file_section_parser_core
// object file byte stream parser with decoupled parse and output stages
// ----------------------------------------------------------------------------
// slave side takes one stream byte per transaction in s_tdata[7:0]. each
// section header (tag, address, count; 16-bit big-endian words) is parsed
// and the body turns into results on the master side: code or data word
// writes, label characters (tlast on the last one) or one unknown-tag record.
// throughput: one byte per cycle while s_tready is high; the parser updates its state on every byte taken.
// a result is queued at the edge that takes the byte completing it and is
// then loaded into the output register, which drives m_tvalid, once that
// register is free.
// reset clears the parser, empties the queue and drops m_tvalid; the next
// byte is taken as the start of a header.
// when the receiver stalls, results pile up in the QUEUE_DEPTH entry queue
// plus the output register; s_tready falls once the queue is full and rises
// again as soon as an entry drains.
// ----------------------------------------------------------------------------
module object_file_section_parser_core #(
  parameter int QUEUE_DEPTH = ofsp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] target_address, [31:16] value
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // label_end
);
  import ofsp_pkg::*;

  logic    accept;
  logic    push, pop, q_empty, q_full;
  result_t front_result, q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  ofsp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_tdata),
    .push    (push),
    .result  (front_result)
  );

  ofsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_result),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ofsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/ofsp_checker.sv =====
// ----------------------------------------------------------------------------
// ofsp_checker
// port level checks of the object file section parser
// ----------------------------------------------------------------------------
`include "object_file_section_parser_core_defines.svh"

module ofsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import ofsp_pkg::*;

  // a stalled result holds
  `OFSP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // only label characters carry tlast
  `OFSP_ASSERT(a_last_is_label, m_tvalid && m_tlast |-> m_tuser == KIND_LABEL, "tlast on a non-label result")

  // label characters leave the high value byte clear
  `OFSP_ASSERT(a_label_byte, m_tvalid && m_tuser == KIND_LABEL |-> m_tdata[31:24] == 8'd0, "label value above one byte")

  // reset drops any pending result
  `OFSP_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind object_file_section_parser_core ofsp_checker u_ofsp_checker (.*);
